// ===== src/assert_macros.svh =====
// Assertion macros shared by the encoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define MTEE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define MTEE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/mtee_pkg.sv =====
// Types, constants and byte codes for the track event encoder.
package mtee_pkg;

  // Field widths
  localparam int TickW    = 28;
  localparam int ChanW    = 4;
  localparam int NoteW    = 7;
  localparam int ValueW   = 7;
  localparam int CmdW     = 3;
  localparam int TempoW   = 24;
  localparam int CfgDataW = 24;
  localparam int CfgIdxW  = 2;

  // Delta time encoding
  localparam int DELTA_BYTES_MAX = 4;
  localparam int DeltaBits = 7 * DELTA_BYTES_MAX;
  localparam logic [TickW-1:0] DeltaLimit = TickW'((64'd1 << DeltaBits) - 64'd1);

  // Event frame sizing
  localparam int MaxBytes = 8;
  localparam int IdxW     = $clog2(MaxBytes);
  localparam int CountW   = $clog2(MaxBytes + 1);
  localparam int TailMax  = 3;
  localparam int TailIdxW = $clog2(TailMax);

  // Queue between front and back
  localparam int FifoDepth = 2;
  localparam int FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_TEMPO     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BEATS     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BEAT_UNIT = 2'd2;

  // Reset values
  localparam logic [TempoW-1:0] TempoReset    = 24'd500000;
  localparam logic [7:0]        BeatsReset    = 8'd4;
  localparam logic [7:0]        BeatUnitReset = 8'd4;

  // Event commands
  typedef enum logic [CmdW-1:0] {
    CMD_NOTE_ON  = 3'd0,
    CMD_NOTE_OFF = 3'd1,
    CMD_PROGRAM  = 3'd2,
    CMD_EOT      = 3'd3,
    CMD_TEMPO    = 3'd4,
    CMD_TIMESIG  = 3'd5
  } cmd_e;

  // Track byte codes
  localparam logic [7:0] ST_NOTE_ON   = 8'h90;
  localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
  localparam logic [7:0] ST_PROGRAM   = 8'hC0;
  localparam logic [7:0] REL_VELOCITY = 8'h40;
  localparam logic [7:0] META_PREFIX  = 8'hFF;
  localparam logic [7:0] META_TEMPO   = 8'h51;
  localparam logic [7:0] META_TIMESIG = 8'h58;
  localparam logic [7:0] META_EOT     = 8'h2F;
  localparam logic [7:0] TEMPO_LEN    = 8'h03;
  localparam logic [7:0] TIMESIG_LEN  = 8'h04;
  localparam logic [7:0] EOT_LEN      = 8'h00;
  localparam logic [7:0] ZERO_DELTA   = 8'h00;
  localparam logic [7:0] CLOCKS_CLICK = 8'h18;
  localparam logic [7:0] NOTATED_32ND = 8'h08;

  // One encoded event: bytes in send order, slot 0 first
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CountW-1:0]        count;
  } frame_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== src/mtee_if.sv =====
// Input and output channel interfaces of the encoder.
interface mtee_in_if;
  logic                        valid;
  logic                        ready;
  logic [mtee_pkg::CmdW-1:0]   cmd;
  logic [mtee_pkg::TickW-1:0]  tick;
  logic [mtee_pkg::ChanW-1:0]  channel;
  logic [mtee_pkg::NoteW-1:0]  note;
  logic [mtee_pkg::ValueW-1:0] value;

  modport source (output valid, cmd, tick, channel, note, value, input ready);
  modport sink   (input valid, cmd, tick, channel, note, value, output ready);
endinterface

interface mtee_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

// ===== src/mtee_fifo.sv =====
// Short frame queue between the classifier and the byte serializer.
`include "assert_macros.svh"

module mtee_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  mtee_pkg::frame_t     frame_i,
  input  logic                 pop_i,
  output mtee_pkg::frame_t     frame_o,
  output mtee_pkg::fifo_stat_t stat_o
);

  mtee_pkg::frame_t                   mem_q [mtee_pkg::FifoDepth];
  logic [mtee_pkg::FifoPtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [mtee_pkg::FifoPtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [mtee_pkg::FifoCntW-1:0]      cnt_q, cnt_d;

  localparam logic [mtee_pkg::FifoPtrW-1:0] PtrLast =
    mtee_pkg::FifoPtrW'(mtee_pkg::FifoDepth - 1);
  localparam logic [mtee_pkg::FifoCntW-1:0] CntFull =
    mtee_pkg::FifoCntW'(mtee_pkg::FifoDepth);

  assign stat_o.full  = (cnt_q == CntFull);
  assign stat_o.empty = (cnt_q == '0);
  assign frame_o      = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= frame_i;
    end
  end

  `MTEE_ASSERT(a_no_push_full, clk_i, rst_ni, push_i |-> !stat_o.full, "push into full queue")
  `MTEE_ASSERT(a_no_pop_empty, clk_i, rst_ni, pop_i |-> !stat_o.empty, "pop from empty queue")
  `MTEE_ASSERT_ALWAYS(a_cnt_range, clk_i, cnt_q <= CntFull, "queue count out of range")

endmodule

// ===== src/mtee_front.sv =====
// Front end: accepts events, tracks time, builds the byte frame of each event.
module mtee_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mtee_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [mtee_pkg::CfgDataW-1:0]     cfg_data_i,
  mtee_in_if.sink                           in_i,
  input  mtee_pkg::fifo_stat_t              stat_i,
  output logic                              push_o,
  output mtee_pkg::frame_t                  frame_o
);

  logic [mtee_pkg::TempoW-1:0] tempo_q;
  logic [7:0]                  beats_q;
  logic [7:0]                  beat_unit_q;
  logic [mtee_pkg::TickW-1:0]  prev_tick_q, prev_tick_d;

  logic                        accept;
  logic                        cmd_ok;
  logic [mtee_pkg::TickW-1:0]  delta_raw, delta_sat, delta_sh;
  logic [mtee_pkg::CountW-1:0] groups, gi, kk, ti, tail_n;
  logic [mtee_pkg::TailMax-1:0][7:0] tail;
  logic [2:0]                  log2_unit;
  logic [7:0]                  chan_byte;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tempo_q     <= mtee_pkg::TempoReset;
      beats_q     <= mtee_pkg::BeatsReset;
      beat_unit_q <= mtee_pkg::BeatUnitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mtee_pkg::CFG_TEMPO:     tempo_q     <= cfg_data_i[mtee_pkg::TempoW-1:0];
        mtee_pkg::CFG_BEATS:     beats_q     <= cfg_data_i[7:0];
        mtee_pkg::CFG_BEAT_UNIT: beat_unit_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Handshake: events flow whenever the queue has room
  assign in_i.ready = !stat_i.full;
  assign accept     = in_i.valid && in_i.ready;
  assign cmd_ok     = (in_i.cmd <= mtee_pkg::CMD_TIMESIG);
  assign push_o     = accept && cmd_ok;

  // Delta time: clamp negative, saturate to the encodable range
  assign delta_raw = (in_i.tick >= prev_tick_q) ? in_i.tick - prev_tick_q : '0;
  assign delta_sat = (delta_raw > mtee_pkg::DeltaLimit) ? mtee_pkg::DeltaLimit : delta_raw;

  // Number of seven-bit groups in the delta
  always_comb begin
    groups = mtee_pkg::CountW'(1);
    for (int g = 1; g < mtee_pkg::DELTA_BYTES_MAX; g++) begin
      if ((delta_sat >> (7 * g)) != '0) begin
        groups = mtee_pkg::CountW'(g + 1);
      end
    end
  end

  // floor(log2) of the beat unit; zero and one give zero
  always_comb begin
    log2_unit = '0;
    for (int i = 1; i < 8; i++) begin
      if (beat_unit_q[i]) begin
        log2_unit = 3'(i);
      end
    end
  end

  // Status and data bytes that follow the delta of a channel event
  always_comb begin
    tail   = '0;
    tail_n = '0;
    chan_byte = {4'h0, in_i.channel};
    unique case (in_i.cmd)
      mtee_pkg::CMD_NOTE_ON: begin
        tail[0] = mtee_pkg::ST_NOTE_ON | chan_byte;
        tail[1] = {1'b0, in_i.note};
        tail[2] = {1'b0, in_i.value};
        tail_n  = mtee_pkg::CountW'(3);
      end
      mtee_pkg::CMD_NOTE_OFF: begin
        tail[0] = mtee_pkg::ST_NOTE_OFF | chan_byte;
        tail[1] = {1'b0, in_i.note};
        tail[2] = mtee_pkg::REL_VELOCITY;
        tail_n  = mtee_pkg::CountW'(3);
      end
      mtee_pkg::CMD_PROGRAM: begin
        tail[0] = mtee_pkg::ST_PROGRAM | chan_byte;
        tail[1] = {1'b0, in_i.value};
        tail_n  = mtee_pkg::CountW'(2);
      end
      default: ;
    endcase
  end

  // Frame assembly
  always_comb begin
    frame_o  = '0;
    gi       = '0;
    kk       = '0;
    ti       = '0;
    delta_sh = '0;
    unique case (in_i.cmd) inside
      mtee_pkg::CMD_NOTE_ON, mtee_pkg::CMD_NOTE_OFF, mtee_pkg::CMD_PROGRAM: begin
        // delta groups most significant first, then the tail bytes
        for (int k = 0; k < mtee_pkg::MaxBytes; k++) begin
          kk = mtee_pkg::CountW'(k);
          if (kk < groups) begin
            gi       = groups - mtee_pkg::CountW'(1) - kk;
            delta_sh = delta_sat >> (7 * gi);
            frame_o.bytes[k] = {(gi != '0), delta_sh[6:0]};
          end else begin
            ti = kk - groups;
            if (ti < mtee_pkg::CountW'(mtee_pkg::TailMax)) begin
              frame_o.bytes[k] = tail[ti[mtee_pkg::TailIdxW-1:0]];
            end
          end
        end
        frame_o.count = groups + tail_n;
      end
      mtee_pkg::CMD_EOT: begin
        frame_o.bytes[0] = mtee_pkg::ZERO_DELTA;
        frame_o.bytes[1] = mtee_pkg::META_PREFIX;
        frame_o.bytes[2] = mtee_pkg::META_EOT;
        frame_o.bytes[3] = mtee_pkg::EOT_LEN;
        frame_o.count    = mtee_pkg::CountW'(4);
      end
      mtee_pkg::CMD_TEMPO: begin
        frame_o.bytes[0] = mtee_pkg::ZERO_DELTA;
        frame_o.bytes[1] = mtee_pkg::META_PREFIX;
        frame_o.bytes[2] = mtee_pkg::META_TEMPO;
        frame_o.bytes[3] = mtee_pkg::TEMPO_LEN;
        frame_o.bytes[4] = tempo_q[23:16];
        frame_o.bytes[5] = tempo_q[15:8];
        frame_o.bytes[6] = tempo_q[7:0];
        frame_o.count    = mtee_pkg::CountW'(7);
      end
      mtee_pkg::CMD_TIMESIG: begin
        frame_o.bytes[0] = mtee_pkg::ZERO_DELTA;
        frame_o.bytes[1] = mtee_pkg::META_PREFIX;
        frame_o.bytes[2] = mtee_pkg::META_TIMESIG;
        frame_o.bytes[3] = mtee_pkg::TIMESIG_LEN;
        frame_o.bytes[4] = beats_q;
        frame_o.bytes[5] = {5'b0, log2_unit};
        frame_o.bytes[6] = mtee_pkg::CLOCKS_CLICK;
        frame_o.bytes[7] = mtee_pkg::NOTATED_32ND;
        frame_o.count    = mtee_pkg::CountW'(8);
      end
      default: ;
    endcase
  end

  // Previous tick: channel events set it, end of track clears it
  always_comb begin
    prev_tick_d = prev_tick_q;
    if (accept) begin
      case (in_i.cmd) inside
        mtee_pkg::CMD_NOTE_ON, mtee_pkg::CMD_NOTE_OFF, mtee_pkg::CMD_PROGRAM:
          prev_tick_d = in_i.tick;
        mtee_pkg::CMD_EOT:
          prev_tick_d = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_tick_q <= '0;
    end else begin
      prev_tick_q <= prev_tick_d;
    end
  end

endmodule

// ===== src/mtee_back.sv =====
// Back end: sends the bytes of each queued frame, one per cycle while the output is ready.
`include "assert_macros.svh"

module mtee_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mtee_pkg::frame_t     frame_i,
  input  mtee_pkg::fifo_stat_t stat_i,
  output logic                 pop_o,
  mtee_out_if.source           out_o
);

  mtee_pkg::frame_t              cur_q;
  logic                          cur_valid_q, cur_valid_d;
  logic [mtee_pkg::IdxW-1:0]     idx_q, idx_d;
  logic                          is_last;
  logic                          out_acc;

  // Output straight from the frame register
  assign is_last         = (mtee_pkg::CountW'(idx_q) + mtee_pkg::CountW'(1)) == cur_q.count;
  assign out_o.valid     = cur_valid_q;
  assign out_o.out_byte  = cur_q.bytes[idx_q];
  assign out_o.last_byte = is_last;
  assign out_acc         = out_o.valid && out_o.ready;

  // Load the next frame when idle or when the final byte leaves
  assign pop_o = !stat_i.empty && (!cur_valid_q || (out_acc && is_last));

  always_comb begin
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    if (pop_o) begin
      cur_valid_d = 1'b1;
      idx_d       = '0;
    end else if (out_acc) begin
      if (is_last) begin
        cur_valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= frame_i;
    end
  end

  `MTEE_ASSERT(a_idx_in_frame, clk_i, rst_ni, cur_valid_q |-> (mtee_pkg::CountW'(idx_q) < cur_q.count), "byte index past frame end")
  `MTEE_ASSERT(a_mid_frame_stays, clk_i, rst_ni, (out_acc && !is_last) |=> cur_valid_q, "frame dropped before its last byte")
  `MTEE_ASSERT(a_idx_steps, clk_i, rst_ni, (out_acc && !is_last) |=> (idx_q == $past(idx_q) + 1'b1), "byte index skipped")

endmodule

// ===== src/midi_track_event_encoder_top.sv =====
// Top level of the track event encoder: classifier, frame queue, byte serializer.
//
//   channel  dir  payload                                  handshake
//   in_i     in   cmd, tick, channel, note, value          valid/ready
//   out_o    out  out_byte, last_byte                      valid/ready
//   cfg_*    in   cfg_idx_i, cfg_data_i (24 bit)           cfg_we_i, no wait
//
// Input takes one event per cycle while the two-entry frame queue has room.
// Output sends one byte per cycle while the receiver is ready, 3 to 8 bytes per
// defined command and none for unused codes; the single byte port of the
// serializer limits the sustained event rate. Each event passes the frame queue
// and then the frame register before its first byte is offered. Reset gives
// previous tick 0 and the register reset values; a stalled output holds its byte
// and the queue absorbs input.
module midi_track_event_encoder_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mtee_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mtee_pkg::CfgDataW-1:0] cfg_data_i,
  mtee_in_if.sink                       in_i,
  mtee_out_if.source                    out_o
);

  logic                 push;
  logic                 pop;
  mtee_pkg::frame_t     frame_in;
  mtee_pkg::frame_t     frame_out;
  mtee_pkg::fifo_stat_t stat;

  mtee_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .stat_i     (stat),
    .push_o     (push),
    .frame_o    (frame_in)
  );

  mtee_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .frame_i (frame_in),
    .pop_i   (pop),
    .frame_o (frame_out),
    .stat_o  (stat)
  );

  mtee_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .frame_i (frame_out),
    .stat_i  (stat),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the MIDI track event encoder: random and directed events.
module testbench;

  // Codes outside the command set, the block drops them
  localparam logic [mtee_pkg::CmdW-1:0]    CMD_RSVD_A = 3'd6;
  localparam logic [mtee_pkg::CmdW-1:0]    CMD_RSVD_B = 3'd7;
  // Register index past the last register, writes to it are dropped
  localparam logic [mtee_pkg::CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  localparam int StallLimit = 2000;  // cycles with no handshake at all
  localparam int LongHold   = 300;   // receiver hold-off when the queue must fill
  localparam int SettleCyc  = 8;     // quiet cycles after the last byte
  localparam int ReportMax  = 10;

  typedef struct packed {
    logic [mtee_pkg::CmdW-1:0]   cmd;
    logic [mtee_pkg::TickW-1:0]  tick;
    logic [mtee_pkg::ChanW-1:0]  channel;
    logic [mtee_pkg::NoteW-1:0]  note;
    logic [mtee_pkg::ValueW-1:0] value;
  } track_event_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } track_byte_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [mtee_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [mtee_pkg::CfgDataW-1:0] cfg_data_i;

  mtee_in_if  in_if ();
  mtee_out_if out_if ();

  midi_track_event_encoder_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state and register copies
  logic [mtee_pkg::TickW-1:0]  last_tick;
  logic [mtee_pkg::TempoW-1:0] tempo_us;
  logic [7:0]                  beats_num;
  logic [7:0]                  unit_val;

  track_event_t pending_events[$];
  track_byte_t  expected_bytes[$];
  track_event_t offered;
  logic [mtee_pkg::TickW-1:0] gen_tick;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_requests;
  int holds_served;
  int hold_left;
  int quiet_cycles;
  int error_count = 0;
  logic [15:0] pad;

  // Append one event to the pending list
  function automatic void add_event(track_event_t e);
    pending_events.insert(pending_events.size(), e);
  endfunction

  // Expected track bytes for one accepted event
  function automatic void encode_event(track_event_t e);
    logic [7:0]                 frame[$];
    logic [mtee_pkg::TickW-1:0] delta;
    logic [7:0]                 v;
    logic [7:0]                 lg;
    int                         groups;
    int                         g;
    track_byte_t                out_item;
    case (e.cmd)
      mtee_pkg::CMD_NOTE_ON, mtee_pkg::CMD_NOTE_OFF, mtee_pkg::CMD_PROGRAM: begin
        delta = (e.tick >= last_tick) ? e.tick - last_tick : '0;
        if (delta > mtee_pkg::DeltaLimit) delta = mtee_pkg::DeltaLimit;
        groups = 1;
        while (groups < mtee_pkg::DELTA_BYTES_MAX && (delta >> (7 * groups)) != 0) groups++;
        // variable-length quantity, most significant group first
        for (g = groups - 1; g >= 0; g--) begin
          frame.insert(frame.size(), {(g > 0), delta[7*g +: 7]});
        end
        if (e.cmd == mtee_pkg::CMD_NOTE_ON) begin
          frame.insert(frame.size(), mtee_pkg::ST_NOTE_ON | 8'(e.channel));
          frame.insert(frame.size(), 8'(e.note));
          frame.insert(frame.size(), 8'(e.value));
        end else if (e.cmd == mtee_pkg::CMD_NOTE_OFF) begin
          frame.insert(frame.size(), mtee_pkg::ST_NOTE_OFF | 8'(e.channel));
          frame.insert(frame.size(), 8'(e.note));
          frame.insert(frame.size(), mtee_pkg::REL_VELOCITY);
        end else begin
          frame.insert(frame.size(), mtee_pkg::ST_PROGRAM | 8'(e.channel));
          frame.insert(frame.size(), 8'(e.value));
        end
        last_tick = e.tick;
      end
      mtee_pkg::CMD_EOT: begin
        frame = '{mtee_pkg::ZERO_DELTA, mtee_pkg::META_PREFIX, mtee_pkg::META_EOT,
                  mtee_pkg::EOT_LEN};
        last_tick = '0;
      end
      mtee_pkg::CMD_TEMPO: begin
        frame = '{mtee_pkg::ZERO_DELTA, mtee_pkg::META_PREFIX, mtee_pkg::META_TEMPO,
                  mtee_pkg::TEMPO_LEN, tempo_us[23:16], tempo_us[15:8], tempo_us[7:0]};
      end
      mtee_pkg::CMD_TIMESIG: begin
        // denominator goes out as floor log2, zero and one both give 0
        v  = unit_val;
        lg = '0;
        while (v > 8'd1) begin
          v  = v >> 1;
          lg = lg + 8'd1;
        end
        frame = '{mtee_pkg::ZERO_DELTA, mtee_pkg::META_PREFIX, mtee_pkg::META_TIMESIG,
                  mtee_pkg::TIMESIG_LEN, beats_num, lg, mtee_pkg::CLOCKS_CLICK,
                  mtee_pkg::NOTATED_32ND};
      end
      default: ;
    endcase
    foreach (frame[i]) begin
      out_item = {frame[i], i == frame.size() - 1};
      expected_bytes.insert(expected_bytes.size(), out_item);
    end
  endfunction

  function automatic track_event_t mk_event(logic [mtee_pkg::CmdW-1:0] cmd,
                                            logic [mtee_pkg::TickW-1:0] tick,
                                            logic [mtee_pkg::ChanW-1:0] ch,
                                            logic [mtee_pkg::NoteW-1:0] note,
                                            logic [mtee_pkg::ValueW-1:0] value);
    track_event_t e;
    e.cmd     = cmd;
    e.tick    = tick;
    e.channel = ch;
    e.note    = note;
    e.value   = value;
    return e;
  endfunction

  // Mostly in-order channel events with deltas of every length, some noise
  function automatic track_event_t random_event();
    track_event_t               e;
    int unsigned                pick;
    logic [mtee_pkg::TickW-1:0] step;
    pick = $urandom_range(99);
    e = mk_event(mtee_pkg::CMD_NOTE_ON, mtee_pkg::TickW'($urandom),
                 mtee_pkg::ChanW'($urandom), mtee_pkg::NoteW'($urandom),
                 mtee_pkg::ValueW'($urandom));
    if (pick < 70) begin
      e.cmd = mtee_pkg::CmdW'($urandom_range(mtee_pkg::CMD_PROGRAM));
      case ($urandom_range(4))
        0:       step = '0;
        1:       step = mtee_pkg::TickW'($urandom_range(127, 1));
        2:       step = mtee_pkg::TickW'($urandom_range(16383, 128));
        3:       step = mtee_pkg::TickW'($urandom_range(2097151, 16384));
        default: step = mtee_pkg::TickW'($urandom_range(mtee_pkg::DeltaLimit, 2097152));
      endcase
      e.tick   = gen_tick + step;
      gen_tick = e.tick;
    end else if (pick < 78) begin
      // arbitrary tick, often behind the previous one
      e.cmd    = mtee_pkg::CmdW'($urandom_range(mtee_pkg::CMD_PROGRAM));
      gen_tick = e.tick;
    end else if (pick < 86) begin
      e.cmd = mtee_pkg::CMD_TEMPO;
    end else if (pick < 94) begin
      e.cmd = mtee_pkg::CMD_TIMESIG;
    end else if (pick < 98) begin
      e.cmd    = mtee_pkg::CMD_EOT;
      gen_tick = '0;
    end else begin
      e.cmd = (pick == 98) ? CMD_RSVD_A : CMD_RSVD_B;
    end
    return e;
  endfunction

  // Input driver: pops one item at a time, random gaps between items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.cmd     <= '0;
      in_if.tick    <= '0;
      in_if.channel <= '0;
      in_if.note    <= '0;
      in_if.value   <= '0;
      last_tick      = '0;
    end else begin
      if (in_if.valid && in_if.ready) encode_event(offered);
      if (!in_if.valid || in_if.ready) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = pending_events.pop_front();
          in_if.valid   <= 1'b1;
          in_if.cmd     <= offered.cmd;
          in_if.tick    <= offered.tick;
          in_if.channel <= offered.channel;
          in_if.note    <= offered.note;
          in_if.value   <= offered.value;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Output ready: random stalls, plus long hold-offs on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_left    <= 0;
      holds_served <= 0;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left    <= LongHold;
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void flag_error(string msg);
    if (error_count < ReportMax) $display("mismatch at %0t: %s", $time, msg);
    error_count++;
  endfunction

  // Output monitor: each byte against the oldest expected one
  always @(posedge clk_i) begin
    track_byte_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_bytes.size() == 0) begin
        flag_error($sformatf("unexpected byte %02h last %0b", out_if.out_byte,
                             out_if.last_byte));
      end else begin
        want = expected_bytes.pop_front();
        if (want.data !== out_if.out_byte || want.last !== out_if.last_byte)
          flag_error($sformatf("byte %02h last %0b, expected %02h last %0b",
                               out_if.out_byte, out_if.last_byte, want.data, want.last));
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("** midi_track_event_encoder_top: FAILED **");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Wait until every item is taken and every byte is out, then let it settle
  task automatic wait_idle();
    @(negedge clk_i);
    while (pending_events.size() != 0 || in_if.valid || expected_bytes.size() != 0)
      @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [mtee_pkg::CfgIdxW-1:0] idx,
                           input logic [mtee_pkg::CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      mtee_pkg::CFG_TEMPO:     tempo_us  = data;
      mtee_pkg::CFG_BEATS:     beats_num = data[7:0];
      mtee_pkg::CFG_BEAT_UNIT: unit_val  = data[7:0];
      default: ;
    endcase
  endtask

  // One stretch of traffic at a given idle mix, always with a tempo and a time signature event
  task automatic run_phase(input int idle_pct, input int stall_pct, input int count,
                           input bit hold);
    @(negedge clk_i);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    add_event(mk_event(mtee_pkg::CMD_TEMPO, '0, '0, '0, '0));
    add_event(mk_event(mtee_pkg::CMD_TIMESIG, '1, '1, '1, '1));
    repeat (count) add_event(random_event());
    if (hold) hold_requests++;
    wait_idle();
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requests  = 0;
    gen_tick       = '0;
    tempo_us       = mtee_pkg::TempoReset;
    beats_num      = mtee_pkg::BeatsReset;
    unit_val       = mtee_pkg::BeatUnitReset;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: every delta length and its boundaries, backward and equal
    // ticks, largest delta, unused codes, meta events at reset values
    add_event(mk_event(mtee_pkg::CMD_NOTE_ON,  28'd0,       4'd0,  7'd0,   7'd0));
    add_event(mk_event(mtee_pkg::CMD_NOTE_ON,  28'd127,     4'd15, 7'd127, 7'd127));
    add_event(mk_event(mtee_pkg::CMD_NOTE_OFF, 28'd255,     4'd5,  7'd60,  7'd7));
    add_event(mk_event(mtee_pkg::CMD_PROGRAM,  28'd16638,   4'd9,  7'd0,   7'd127));
    add_event(mk_event(mtee_pkg::CMD_NOTE_ON,  28'd33022,   4'd3,  7'd64,  7'd100));
    add_event(mk_event(mtee_pkg::CMD_NOTE_OFF, 28'd2130173, 4'd2,  7'd1,   7'd127));
    add_event(mk_event(mtee_pkg::CMD_PROGRAM,  28'd4227325, 4'd1,  7'd127, 7'd0));
    add_event(mk_event(mtee_pkg::CMD_NOTE_ON,  '1,          4'd15, 7'd85,  7'd42));
    add_event(mk_event(mtee_pkg::CMD_NOTE_OFF, 28'd5,       4'd7,  7'd42,  7'd85));
    add_event(mk_event(mtee_pkg::CMD_NOTE_ON,  28'd5,       4'd8,  7'd12,  7'd1));
    add_event(mk_event(mtee_pkg::CMD_TEMPO,    '1,          '1,    '1,     '1));
    add_event(mk_event(mtee_pkg::CMD_TIMESIG,  '0,          '0,    '0,     '0));
    add_event(mk_event(mtee_pkg::CMD_EOT,      '1,          '1,    '1,     '1));
    add_event(mk_event(mtee_pkg::CMD_NOTE_ON,  '1,          4'd10, 7'd99,  7'd33));
    add_event(mk_event(CMD_RSVD_A,             '1,          '1,    '1,     '1));
    add_event(mk_event(CMD_RSVD_B,             28'd77,      4'd3,  7'd3,   7'd3));
    add_event(mk_event(mtee_pkg::CMD_PROGRAM,  28'd200,     4'd6,  7'd127, 7'd55));
    add_event(mk_event(mtee_pkg::CMD_EOT,      '0,          '0,    '0,     '0));
    wait_idle();

    // Low register extremes; receiver holds off so the input backs up
    pad = $urandom;
    write_reg(mtee_pkg::CFG_TEMPO, '0);
    write_reg(mtee_pkg::CFG_BEATS, {pad, 8'd0});
    write_reg(mtee_pkg::CFG_BEAT_UNIT, {~pad, 8'd1});
    run_phase(0, 0, 80, 1'b1);

    // High extremes, and a write to an unused index
    write_reg(mtee_pkg::CFG_TEMPO, '1);
    write_reg(mtee_pkg::CFG_BEATS, '1);
    write_reg(mtee_pkg::CFG_BEAT_UNIT, '1);
    write_reg(CFG_UNUSED, mtee_pkg::CfgDataW'($urandom));
    run_phase(76, 0, 80, 1'b0);

    // Random tempo and numerator, denominator zero
    pad = $urandom;
    write_reg(mtee_pkg::CFG_TEMPO, mtee_pkg::CfgDataW'($urandom));
    write_reg(mtee_pkg::CFG_BEATS, mtee_pkg::CfgDataW'($urandom));
    write_reg(mtee_pkg::CFG_BEAT_UNIT, {pad, 8'd0});
    run_phase(0, 76, 80, 1'b0);

    // Random settings, both sides idling; sender pauses halfway for a full drain
    write_reg(mtee_pkg::CFG_TEMPO, mtee_pkg::CfgDataW'($urandom));
    write_reg(mtee_pkg::CFG_BEATS, mtee_pkg::CfgDataW'($urandom));
    write_reg(mtee_pkg::CFG_BEAT_UNIT, mtee_pkg::CfgDataW'($urandom_range(255, 1)));
    run_phase(22, 22, 40, 1'b0);
    run_phase(22, 22, 40, 1'b0);

    if (error_count == 0 && expected_bytes.size() == 0) begin
      $display("** midi_track_event_encoder_top: PASSED **");
    end else begin
      $display("** midi_track_event_encoder_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== midi_track_event_encoder_top.f =====
+incdir+src
src/mtee_pkg.sv
src/mtee_if.sv
src/mtee_fifo.sv
src/mtee_front.sv
src/mtee_back.sv
src/midi_track_event_encoder_top.sv
tb/sv/testbench.sv
